// ===== hw/rtl/ir90_pkg.sv =====
// ir90_pkg: shared constants, types and helpers for the 90 degree frame rotator.
// No dependencies; used by ir90_frame_ram and image_rotate_90_core.
package ir90_pkg;

    localparam int MAX_DIM    = 256;
    localparam int MAX_PIXELS = 65536;

    localparam int DIM_W   = 9;                    // config register width
    localparam int COORD_W = 8;                    // rotated row / column index
    localparam int ADDR_W  = $clog2(MAX_PIXELS);   // frame store address
    localparam int TOTAL_W = ADDR_W + 1;           // pixel count, holds MAX_PIXELS
    localparam int PIX_W   = 24;
    localparam int PROD_W  = 2 * DIM_W;

    // register indexes on the config port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

    // zero acts as one, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ir90_frame_ram.sv =====
// ir90_frame_ram: single write port, single read port frame store with a registered read.
// Depends on ir90_pkg.
module ir90_frame_ram (
    input  logic                         aclk,
    input  ir90_pkg::ram_wr_t            wr,
    input  ir90_pkg::ram_rd_t            rd,
    output logic [ir90_pkg::PIX_W-1:0]   rd_data
);
    import ir90_pkg::*;

    logic [PIX_W-1:0] frame_mem [MAX_PIXELS];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            frame_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= frame_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/image_rotate_90_core.sv =====
// image_rotate_90_core: top level of the 90 degree frame rotator.
// Depends on ir90_pkg and ir90_frame_ram.
//
//  channel   direction  ports                                       notes
//  s_*       in         s_valid s_ready s_command s_pixel_in        load or read command
//  m_*       out        m_valid m_ready m_pixel_out m_out_row       one transfer per read
//                       m_out_col m_last_pixel
//  cfg_*     in         cfg_wr_en cfg_index cfg_wdata               width / height writes
//
// Throughput: one command per cycle while s_ready is high. A load writes the frame
// store at its accept edge. A read issues its store read at the accept edge; the result
// is presented the next cycle from the RAM read register, so the RAM read port sets the latency.
// Reset (aresetn, synchronous, active low) clears counters and the output valid and
// sets both dimensions to 1. The store itself is not cleared.
// Stalls: while a result waits on m_ready, s_ready is low; a result taken in the same
// cycle frees the slot for the next command.
module image_rotate_90_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [ir90_pkg::PIX_W-1:0]    s_pixel_in,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ir90_pkg::PIX_W-1:0]    m_pixel_out,
    output logic [ir90_pkg::COORD_W-1:0]  m_out_row,
    output logic [ir90_pkg::COORD_W-1:0]  m_out_col,
    output logic                          m_last_pixel,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [ir90_pkg::DIM_W-1:0]    cfg_wdata
);
    import ir90_pkg::*;

    // effective dimensions and pixel count, kept already clamped
    logic [DIM_W-1:0]   w_eff_reg, w_eff_next;
    logic [DIM_W-1:0]   h_eff_reg, h_eff_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [PROD_W-1:0]  total_prod;

    // position counters
    logic [ADDR_W-1:0]  load_pos_reg, load_pos_next;
    logic [COORD_W-1:0] emit_row_reg, emit_row_next;
    logic [COORD_W-1:0] emit_col_reg, emit_col_next;

    // output slot
    logic               m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic               out_last_reg;

    logic               accept;
    logic               load_acc;
    logic               read_acc;

    logic [ADDR_W-1:0]  lp_cur;
    logic [TOTAL_W-1:0] lp_inc;
    logic [COORD_W-1:0] row_cur;
    logic [COORD_W-1:0] col_cur;
    logic [DIM_W-1:0]   row_inc;
    logic [DIM_W-1:0]   col_inc;
    logic [PROD_W-1:0]  src_base;
    logic [PROD_W-1:0]  src_addr;
    logic               last_cur;

    ram_wr_t            ram_wr;
    ram_rd_t            ram_rd;
    logic [PIX_W-1:0]   ram_rd_data;

    // ---------------- handshake ----------------
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign load_acc = accept && (s_command == CMD_LOAD);
    assign read_acc = accept && (s_command == CMD_READ);

    // ---------------- config ----------------
    // pixel count is refreshed at the write edge from the new value and the other dim
    always_comb begin
        w_eff_next = w_eff_reg;
        h_eff_next = h_eff_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_WIDTH:  w_eff_next = eff_dim(cfg_wdata);
                REG_HEIGHT: h_eff_next = eff_dim(cfg_wdata);
                default:    w_eff_next = w_eff_reg;
            endcase
        end
        total_prod = PROD_W'(w_eff_next) * PROD_W'(h_eff_next);
        total_next = total_prod[TOTAL_W-1:0];
    end

    // ---------------- load path ----------------
    // a counter left beyond the frame by a size change restarts at zero
    always_comb begin
        lp_cur = (TOTAL_W'(load_pos_reg) >= total_reg) ? '0 : load_pos_reg;
        lp_inc = TOTAL_W'(lp_cur) + TOTAL_W'(1);
        load_pos_next = load_pos_reg;
        if (load_acc) begin
            load_pos_next = (lp_inc >= total_reg) ? '0 : lp_inc[ADDR_W-1:0];
        end
    end

    // ---------------- read path ----------------
    // rotated (row, col) comes from source row col, column w-1-row
    always_comb begin
        if (DIM_W'(emit_row_reg) >= w_eff_reg || DIM_W'(emit_col_reg) >= h_eff_reg) begin
            row_cur = '0;
            col_cur = '0;
        end else begin
            row_cur = emit_row_reg;
            col_cur = emit_col_reg;
        end
        src_base = PROD_W'(col_cur) * PROD_W'(w_eff_reg);
        src_addr = src_base + PROD_W'(w_eff_reg) - PROD_W'(1) - PROD_W'(row_cur);
        last_cur = (DIM_W'(row_cur) == w_eff_reg - DIM_W'(1))
                && (DIM_W'(col_cur) == h_eff_reg - DIM_W'(1));

        row_inc = DIM_W'(row_cur) + DIM_W'(1);
        col_inc = DIM_W'(col_cur) + DIM_W'(1);
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        if (read_acc) begin
            if (col_inc >= h_eff_reg) begin
                emit_col_next = '0;
                emit_row_next = (row_inc >= w_eff_reg) ? '0 : row_inc[COORD_W-1:0];
            end else begin
                emit_row_next = row_cur;
                emit_col_next = col_inc[COORD_W-1:0];
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (read_acc) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- frame store ----------------
    // a load and a read never share an edge, and a write is visible to the next
    // cycle's read, so no forwarding is needed
    assign ram_wr.en   = load_acc;
    assign ram_wr.addr = lp_cur;
    assign ram_wr.data = s_pixel_in;
    assign ram_rd.en   = read_acc;
    assign ram_rd.addr = src_addr[ADDR_W-1:0];

    ir90_frame_ram u_frame_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_eff_reg    <= DIM_W'(1);
            h_eff_reg    <= DIM_W'(1);
            total_reg    <= TOTAL_W'(1);
            load_pos_reg <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            w_eff_reg    <= w_eff_next;
            h_eff_reg    <= h_eff_next;
            total_reg    <= total_next;
            load_pos_reg <= load_pos_next;
            emit_row_reg <= emit_row_next;
            emit_col_reg <= emit_col_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result tags travel alongside the RAM read
    always_ff @(posedge aclk) begin
        if (read_acc) begin
            out_row_reg  <= row_cur;
            out_col_reg  <= col_cur;
            out_last_reg <= last_cur;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = ram_rd_data;
    assign m_out_row    = out_row_reg;
    assign m_out_col    = out_col_reg;
    assign m_last_pixel = out_last_reg;

    // ---------------- assertions ----------------
    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        read_acc |=> m_valid_reg)
        else $error("read transfer did not produce a result");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_acc && !m_valid_reg) |=> !m_valid_reg)
        else $error("load transfer produced a result");

    a_read_addr_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        read_acc |-> (TOTAL_W'(src_addr[ADDR_W-1:0]) < total_reg))
        else $error("rotated read address outside frame");

    a_last_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_last_reg) |->
            ((DIM_W'(out_row_reg) == w_eff_reg - DIM_W'(1))
            && (DIM_W'(out_col_reg) == h_eff_reg - DIM_W'(1))))
        else $error("last flag on a pixel that is not the frame corner");

    a_emit_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (read_acc && last_cur) |=> (emit_row_reg == '0 && emit_col_reg == '0))
        else $error("emit counters did not wrap after the final pixel");

endmodule
